// ===== hdl/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared constants, command codes and the arithmetic unit's request types.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int unsigned StackDepthDef = 128;
  localparam int unsigned DataW         = 32;

  typedef enum logic [3:0] {
    CMD_PUSH  = 4'd0,
    CMD_ADD   = 4'd1,
    CMD_SUB   = 4'd2,
    CMD_MUL   = 4'd3,
    CMD_DIV   = 4'd4,
    CMD_MOD   = 4'd5,
    CMD_PEEK  = 4'd6,
    CMD_DUP   = 4'd7,
    CMD_SWAP  = 4'd8,
    CMD_CLEAR = 4'd9,
    CMD_POPPR = 4'd10
  } cmd_e;

  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_SUB = 3'd1,
    ALU_MUL = 3'd2,
    ALU_DIV = 3'd3,
    ALU_MOD = 3'd4
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

// ===== hdl/rpn_stack_mem.sv =====
// ----------------------------------------------------------------------------
// RPN stack memory
// Single-port-write, single-read stack storage with a registered read.
// ----------------------------------------------------------------------------
module rpn_stack_mem
  import rpn_pkg::*;
#(
  parameter int unsigned Depth = StackDepthDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rpn_serial_alu.sv =====
// ----------------------------------------------------------------------------
// RPN serial arithmetic unit
// Bit-serial adder, shift-and-add multiplier and restoring divider (also used
// for modulo), one bit per cycle, with saturation applied in a final state.
// ----------------------------------------------------------------------------
module rpn_serial_alu
  import rpn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  alu_req_t         req_i,
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  output logic             done_o,
  output logic [DataW-1:0] result_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  localparam logic [31:0] MaxPos = 32'h7FFF_FFFF;
  localparam logic [31:0] MinNeg = 32'h8000_0000;

  state_e      state_q;
  alu_op_e     op_q;
  logic [5:0]  cnt_q;
  logic [32:0] rem_q;
  logic [47:0] wrk_q;
  logic [31:0] dvs_q;
  logic        carry_q;
  logic        sgn_a_q;
  logic        sgn_y_q;
  logic        neg_q;
  logic        done_q;
  logic [31:0] res_q;

  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic        sbit;
  logic        cbit;
  logic [32:0] msum;
  logic [32:0] rsh;
  logic [33:0] diff;
  logic [48:0] mmag;
  logic [31:0] fin;
  logic [31:0] modv;

  assign mag_a = a_i[31] ? (32'd0 - a_i) : a_i;
  assign mag_b = b_i[31] ? (32'd0 - b_i) : b_i;
  assign sbit  = wrk_q[0] ^ dvs_q[0] ^ carry_q;
  assign cbit  = (wrk_q[0] & dvs_q[0]) | (carry_q & (wrk_q[0] ^ dvs_q[0]));
  assign msum  = {1'b0, rem_q[31:0]} + (wrk_q[0] ? {1'b0, dvs_q} : 33'd0);
  assign rsh   = {rem_q[31:0], wrk_q[47]};
  assign diff  = {1'b0, rsh} - {2'b00, dvs_q};
  assign mmag  = {1'b0, rem_q[31:0], wrk_q[31:16]} + {48'd0, |wrk_q[15:0]};
  assign modv  = {rem_q[15:0], 16'd0};

  always_comb begin
    fin = '0;
    case (op_q)
      ALU_ADD, ALU_SUB: begin
        if ((sgn_a_q == sgn_y_q) && (wrk_q[31] != sgn_a_q)) begin
          fin = sgn_a_q ? MinNeg : MaxPos;
        end else begin
          fin = wrk_q[31:0];
        end
      end
      ALU_MUL: begin
        if (neg_q) begin
          fin = (mmag > {17'd0, MinNeg}) ? MinNeg : (32'd0 - mmag[31:0]);
        end else begin
          fin = ({rem_q[31:0], wrk_q[31:16]} > {16'd0, MaxPos}) ? MaxPos
                                                                 : {rem_q[15:0], wrk_q[31:16]};
        end
      end
      ALU_DIV: begin
        if (neg_q) begin
          fin = (wrk_q > {16'd0, MinNeg}) ? MinNeg : (32'd0 - wrk_q[31:0]);
        end else begin
          fin = (wrk_q > {16'd0, MaxPos}) ? MaxPos : wrk_q[31:0];
        end
      end
      ALU_MOD: begin
        fin = neg_q ? (32'd0 - modv) : modv;
      end
      default: fin = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      op_q    <= ALU_ADD;
      cnt_q   <= '0;
    end else begin
      done_q <= (state_q == ST_FIN);
      case (state_q)
        ST_IDLE: begin
          if (req_i.start) begin
            op_q    <= req_i.op;
            state_q <= ST_RUN;
            case (req_i.op)
              ALU_ADD, ALU_SUB: begin
                cnt_q   <= 6'd31;
                wrk_q   <= {16'd0, a_i};
                dvs_q   <= (req_i.op == ALU_SUB) ? ~b_i : b_i;
                carry_q <= (req_i.op == ALU_SUB);
                sgn_a_q <= a_i[31];
                sgn_y_q <= (req_i.op == ALU_SUB) ? ~b_i[31] : b_i[31];
              end
              ALU_MUL: begin
                cnt_q <= 6'd31;
                rem_q <= '0;
                wrk_q <= {16'd0, mag_b};
                dvs_q <= mag_a;
                neg_q <= a_i[31] ^ b_i[31];
              end
              ALU_DIV: begin
                cnt_q <= 6'd47;
                rem_q <= '0;
                wrk_q <= {mag_a, 16'd0};
                dvs_q <= mag_b;
                neg_q <= a_i[31] ^ b_i[31];
              end
              default: begin
                cnt_q <= 6'd47;
                rem_q <= '0;
                wrk_q <= {32'd0, mag_a[31:16]};
                dvs_q <= {16'd0, mag_b[31:16]};
                neg_q <= a_i[31];
              end
            endcase
          end
        end
        ST_RUN: begin
          case (op_q)
            ALU_ADD, ALU_SUB: begin
              wrk_q[31:0] <= {sbit, wrk_q[31:1]};
              dvs_q       <= {1'b0, dvs_q[31:1]};
              carry_q     <= cbit;
            end
            ALU_MUL: begin
              rem_q       <= {1'b0, msum[32:1]};
              wrk_q[31:0] <= {msum[0], wrk_q[31:1]};
            end
            default: begin
              if (!diff[33]) begin
                rem_q <= diff[32:0];
                wrk_q <= {wrk_q[46:0], 1'b1};
              end else begin
                rem_q <= rsh;
                wrk_q <= {wrk_q[46:0], 1'b0};
              end
            end
          endcase
          if (cnt_q == 6'd0) begin
            state_q <= ST_FIN;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        ST_FIN: begin
          res_q   <= fin;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== hdl/rpn_stack_calculator.sv =====
// ----------------------------------------------------------------------------
// RPN stack calculator
// Command-level reverse-Polish calculator on signed Q16.16 values.
// ----------------------------------------------------------------------------
// One command is taken at a time and each gives exactly one result beat.
// Clear and unknown commands go straight to the done state and push goes
// through the push state. Pop-print, peek, dup and swap go through the pop,
// pop-wait and push states they need, as every pop of the stack memory
// waits for its registered read. Add, subtract, multiply, divide and modulo
// pop twice, start the serial arithmetic unit, one bit per cycle, and push
// its result when done; a zero divisor ends the command after the first pop.
// A new command is taken in the cycle after the previous result has been moved
// into the output register, which waits there while the sink stalls.
module rpn_stack_calculator
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // operand_value[31:0]
  input  logic [3:0]  s_axis_tuser_i,  // cmd[3:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // result_value[31:0], underflow_flag[32], overflow_flag[33],
  // zero_divisor_flag[34], unknown_cmd_flag[35], depth_now[43:36], zeros
  output logic [47:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o   // result_valid[0]
);

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned SpW   = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP1,
    ST_POP1_WAIT,
    ST_POP2,
    ST_POP2_WAIT,
    ST_ALU_GO,
    ST_ALU_WAIT,
    ST_PUSH1,
    ST_PUSH2,
    ST_DONE
  } state_e;

  state_e      state_q;
  logic [3:0]  cmd_q;
  logic [31:0] opnd_q;
  logic [31:0] a_q;
  logic [31:0] b_q;
  logic [31:0] res_q;
  logic [SpW-1:0] sp_q;
  logic        hit_q;
  logic        under_q;
  logic        over_q;
  logic        zdiv_q;
  logic        unk_q;
  logic        shown_valid_q;
  logic [31:0] shown_q;
  logic        m_valid_q;
  logic [47:0] m_data_q;
  logic        m_user_q;

  logic [SpW-1:0]   sp_dec;
  logic             empty;
  logic             full;
  logic             mem_we;
  logic [31:0]      mem_wdata;
  logic             mem_re;
  logic [31:0]      mem_rdata;
  logic [31:0]      pop_val;
  logic             alu_done;
  logic [31:0]      alu_res;
  alu_req_t         alu_req;
  logic [31:0]      push_val;
  logic             int_zero;

  assign sp_dec   = sp_q - SpW'(1);
  assign empty    = (sp_q == '0);
  assign full     = (sp_q == SpW'(STACK_DEPTH));
  assign pop_val  = hit_q ? mem_rdata : 32'd0;
  assign int_zero = (pop_val[31:16] == 16'd0) ||
                    ((pop_val[31:16] == 16'hFFFF) && (pop_val[15:0] != 16'd0));

  always_comb begin
    case (cmd_q)
      CMD_PUSH:                   push_val = opnd_q;
      CMD_ADD, CMD_SUB, CMD_MUL,
      CMD_DIV, CMD_MOD:           push_val = res_q;
      default:                    push_val = b_q;
    endcase
    if (state_q == ST_PUSH2 && cmd_q == CMD_SWAP) begin
      push_val = a_q;
    end
  end

  assign mem_we    = ((state_q == ST_PUSH1) || (state_q == ST_PUSH2)) && !full;
  assign mem_wdata = push_val;
  assign mem_re    = ((state_q == ST_POP1) || (state_q == ST_POP2)) && !empty;

  always_comb begin
    alu_req.start = (state_q == ST_ALU_GO);
    case (cmd_q)
      CMD_ADD: alu_req.op = ALU_ADD;
      CMD_SUB: alu_req.op = ALU_SUB;
      CMD_MUL: alu_req.op = ALU_MUL;
      CMD_DIV: alu_req.op = ALU_DIV;
      default: alu_req.op = ALU_MOD;
    endcase
  end

  rpn_stack_mem #(
    .Depth (STACK_DEPTH),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (sp_q[AddrW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (sp_dec[AddrW-1:0]),
    .rdata_o (mem_rdata)
  );

  rpn_serial_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (a_q),
    .b_i      (b_q),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sp_q      <= '0;
      m_valid_q <= 1'b0;
      cmd_q     <= CMD_PUSH;
      hit_q     <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready_i && (state_q != ST_DONE)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            cmd_q         <= s_axis_tuser_i;
            opnd_q        <= s_axis_tdata_i;
            under_q       <= 1'b0;
            over_q        <= 1'b0;
            zdiv_q        <= 1'b0;
            unk_q         <= 1'b0;
            shown_valid_q <= 1'b0;
            shown_q       <= '0;
            case (s_axis_tuser_i)
              CMD_PUSH:  state_q <= ST_PUSH1;
              CMD_CLEAR: begin
                sp_q    <= '0;
                state_q <= ST_DONE;
              end
              CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_PEEK,
              CMD_DUP, CMD_SWAP, CMD_POPPR: state_q <= ST_POP1;
              default: begin
                unk_q   <= 1'b1;
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_POP1, ST_POP2: begin
          hit_q <= !empty;
          if (empty) begin
            under_q <= 1'b1;
          end else begin
            sp_q <= sp_dec;
          end
          state_q <= (state_q == ST_POP1) ? ST_POP1_WAIT : ST_POP2_WAIT;
        end
        ST_POP1_WAIT: begin
          b_q <= pop_val;
          case (cmd_q)
            CMD_DIV: begin
              if (pop_val == 32'd0) begin
                zdiv_q  <= 1'b1;
                state_q <= ST_DONE;
              end else begin
                state_q <= ST_POP2;
              end
            end
            CMD_MOD: begin
              if (int_zero) begin
                zdiv_q  <= 1'b1;
                state_q <= ST_DONE;
              end else begin
                state_q <= ST_POP2;
              end
            end
            CMD_PEEK: begin
              shown_q       <= pop_val;
              shown_valid_q <= 1'b1;
              state_q       <= ST_PUSH1;
            end
            CMD_DUP: state_q <= ST_PUSH1;
            CMD_POPPR: begin
              shown_q       <= pop_val;
              shown_valid_q <= 1'b1;
              state_q       <= ST_DONE;
            end
            default: state_q <= ST_POP2;
          endcase
        end
        ST_POP2_WAIT: begin
          a_q     <= pop_val;
          state_q <= (cmd_q == CMD_SWAP) ? ST_PUSH1 : ST_ALU_GO;
        end
        ST_ALU_GO: state_q <= ST_ALU_WAIT;
        ST_ALU_WAIT: begin
          if (alu_done) begin
            res_q   <= alu_res;
            state_q <= ST_PUSH1;
          end
        end
        ST_PUSH1, ST_PUSH2: begin
          if (full) begin
            over_q <= 1'b1;
          end else begin
            sp_q <= sp_q + SpW'(1);
          end
          if (state_q == ST_PUSH1 && (cmd_q == CMD_DUP || cmd_q == CMD_SWAP)) begin
            state_q <= ST_PUSH2;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {4'd0, 8'(sp_q), unk_q, zdiv_q, over_q, under_q, shown_q};
            m_user_q  <= shown_valid_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

// ===== tb/sv/tb_rpn_stack_calculator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RPN stack calculator testbench
// Sends command beats with random gaps, predicts each result from a local
// copy of the stack, and compares every result beat field by field.
// ----------------------------------------------------------------------------
module tb_rpn_stack_calculator;
  import rpn_pkg::*;

  localparam int unsigned Depth = 128;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] operand;
  } cmd_beat_t;

  typedef struct packed {
    logic [31:0] value;
    logic        shown;
    logic        under;
    logic        over;
    logic        zdiv;
    logic        unknown;
    logic [7:0]  depth;
  } calc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic [3:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  rpn_stack_calculator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  cmd_beat_t    pending_cmds[$];
  calc_result_t expected_results[$];
  logic signed [31:0] calc_stack[Depth];
  int unsigned  calc_sp;
  bit           pred_under, pred_over;
  int           mismatches = 0;
  int           results_seen = 0;
  int           cmds_sent = 0;
  bit           quiet = 1'b0;
  bit           hold_send = 1'b0;
  int           send_idle = 0;
  int           recv_idle = 0;

  function automatic logic signed [31:0] sat_word(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] stack_pop();
    if (calc_sp > 0) begin
      calc_sp--;
      return calc_stack[calc_sp];
    end
    pred_under = 1'b1;
    return '0;
  endfunction

  function automatic void stack_push(logic signed [31:0] v);
    if (calc_sp < Depth) begin
      calc_stack[calc_sp] = v;
      calc_sp++;
    end else begin
      pred_over = 1'b1;
    end
  endfunction

  function automatic calc_result_t execute_cmd(cmd_beat_t c);
    calc_result_t r;
    logic signed [31:0] a, b;
    logic signed [63:0] p, ia, ib;
    r = '0;
    pred_under = 1'b0;
    pred_over = 1'b0;
    case (c.cmd)
      CMD_PUSH: stack_push(c.operand);
      CMD_ADD, CMD_SUB: begin
        b = stack_pop();
        a = stack_pop();
        if (c.cmd == CMD_ADD) stack_push(sat_word(64'(a) + 64'(b)));
        else stack_push(sat_word(64'(a) - 64'(b)));
      end
      CMD_MUL: begin
        b = stack_pop();
        a = stack_pop();
        p = 64'(a) * 64'(b);
        stack_push(sat_word(p >>> 16));
      end
      CMD_DIV: begin
        b = stack_pop();
        if (b != 0) begin
          a = stack_pop();
          p = 64'(a) * 64'sd65536;
          stack_push(sat_word(p / 64'(b)));
        end else begin
          r.zdiv = 1'b1;
        end
      end
      CMD_MOD: begin
        b = stack_pop();
        ib = 64'(b) / 64'sd65536;
        if (ib != 0) begin
          a = stack_pop();
          ia = 64'(a) / 64'sd65536;
          stack_push(sat_word((ia % ib) * 64'sd65536));
        end else begin
          r.zdiv = 1'b1;
        end
      end
      CMD_PEEK: begin
        a = stack_pop();
        r.value = a;
        r.shown = 1'b1;
        stack_push(a);
      end
      CMD_DUP: begin
        a = stack_pop();
        stack_push(a);
        stack_push(a);
      end
      CMD_SWAP: begin
        b = stack_pop();
        a = stack_pop();
        stack_push(b);
        stack_push(a);
      end
      CMD_CLEAR: calc_sp = 0;
      CMD_POPPR: begin
        r.value = stack_pop();
        r.shown = 1'b1;
      end
      default: r.unknown = 1'b1;
    endcase
    r.under = pred_under;
    r.over = pred_over;
    r.depth = calc_sp[7:0];
    return r;
  endfunction

  // Sender side.
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmds_sent <= cmds_sent + 1;
      expected_results.push_back(execute_cmd({s_axis_tuser_i, s_axis_tdata_i}));
    end
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (send_idle > 0) begin
        send_idle <= send_idle - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        send_idle <= $urandom_range(1, 10);
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_cmds.size() > 0 && !hold_send) begin
        s_axis_tvalid_i <= 1'b1;
        {s_axis_tuser_i, s_axis_tdata_i} <= pending_cmds.pop_front();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver side.
  always @(posedge clk_i) begin
    calc_result_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[31:0], m_axis_tuser_o, m_axis_tdata_o[32], m_axis_tdata_o[33],
             m_axis_tdata_o[34], m_axis_tdata_o[35], m_axis_tdata_o[43:36]};
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: value %h/%h shown %b/%b flags u%b o%b z%b k%b / u%b o%b z%b k%b depth %0d/%0d",
                     want.value, got.value, want.shown, got.shown, want.under, want.over,
                     want.zdiv, want.unknown, got.under, got.over, got.zdiv, got.unknown,
                     want.depth, got.depth);
        end
      end
    end
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (recv_idle > 0) begin
      recv_idle <= recv_idle - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      recv_idle <= $urandom_range(1, 10);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 4) << 16;
      3: return -($urandom_range(1, 4) << 16);
      4: return $urandom_range(0, 131071) - 65536;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_cmd(logic [3:0] c, logic [31:0] v = '0);
    pending_cmds.push_back({c, v});
  endtask

  initial begin
    int n, i, k;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-stack cases, extremes, saturation, zero divisors.
    add_cmd(CMD_POPPR);
    add_cmd(CMD_DUP);
    add_cmd(CMD_CLEAR);
    add_cmd(CMD_PEEK);
    add_cmd(CMD_SWAP);
    add_cmd(CMD_CLEAR);
    add_cmd(CMD_CLEAR);
    add_cmd(CMD_PUSH, 32'h7fffffff);
    add_cmd(CMD_PUSH, 32'h7fffffff);
    add_cmd(CMD_ADD);
    add_cmd(CMD_PUSH, 32'h80000000);
    add_cmd(CMD_MUL);
    add_cmd(CMD_PUSH, 32'h00008000);
    add_cmd(CMD_PUSH, 32'h0);
    add_cmd(CMD_DIV);
    add_cmd(CMD_PUSH, 32'hffff8000);
    add_cmd(CMD_MOD);
    add_cmd(CMD_PUSH, 32'hfffb0000);
    add_cmd(CMD_PUSH, 32'h00030000);
    add_cmd(CMD_MOD);
    add_cmd(CMD_PUSH, 32'h80000000);
    add_cmd(CMD_SUB);
    add_cmd(4'd11);
    add_cmd(4'd15);
    add_cmd(CMD_POPPR);

    // Fill past the top so the full-push and dup cases are hit.
    for (i = 0; i < Depth + 2; i++) add_cmd(CMD_PUSH, $urandom);
    add_cmd(CMD_DUP);
    add_cmd(CMD_SWAP);
    add_cmd(CMD_CLEAR);

    // Pause until everything in flight has drained.
    wait (pending_cmds.size() == 0);
    hold_send = 1'b1;
    wait (expected_results.size() == 0 && cmds_sent == 25 + Depth + 5);
    hold_send = 1'b0;

    // Random: mostly short well-formed expressions, some noise.
    n = 0;
    while (n < 1500) begin
      if ($urandom_range(0, 9) < 7) begin
        k = $urandom_range(2, 4);
        for (i = 0; i < k; i++) add_cmd(CMD_PUSH, random_operand());
        for (i = 0; i < k - 1; i++) add_cmd(4'($urandom_range(1, 8)));
        add_cmd($urandom_range(0, 1) ? CMD_POPPR : CMD_PEEK);
        n += 2 * k;
      end else begin
        add_cmd(4'($urandom_range(0, 15)), $urandom);
        n++;
      end
      if (n > 1200) quiet = 1'b1;
      wait (pending_cmds.size() < 8);
    end

    wait (pending_cmds.size() == 0 && !s_axis_tvalid_i && expected_results.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("Ran %0d commands and checked %0d result beats,", cmds_sent, results_seen);
    $display("covering every command, empty and full stack, saturation and zero divisors.");
    if (mismatches == 0 && expected_results.size() == 0)
      $display("rpn_stack_calculator test passed");
    else
      $display("rpn_stack_calculator test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("rpn_stack_calculator test failed");
    $finish;
  end

endmodule

// ===== rpn_stack_calculator.f =====
hdl/rpn_pkg.sv
hdl/rpn_stack_mem.sv
hdl/rpn_serial_alu.sv
hdl/rpn_stack_calculator.sv
tb/sv/tb_rpn_stack_calculator.sv
